// ===== hdl/npi_min_entropy_distribution_unit_defines.svh =====
// Assertion macros used by the checker file of the distribution unit.
`ifndef NPI_MIN_ENTROPY_DISTRIBUTION_UNIT_DEFINES_SVH
`define NPI_MIN_ENTROPY_DISTRIBUTION_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NMED_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define NMED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/nmed_pkg.sv =====
// ----------------------------------------------------------------------------
// Minimum-entropy distribution package
// Sizes, microcode word format and the sequencer program of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmed_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int COUNT_BITS  = 16;

  localparam int IDX_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CNT_W   = $clog2(MAX_CLASSES + 1);
  localparam int BOUND_W = COUNT_BITS + 1;
  localparam int TOTAL_W = COUNT_BITS + $clog2(MAX_CLASSES);
  localparam int WIDE_W  = TOTAL_W + 2;

  localparam int INDEX_OUT_W = 4;
  localparam int BOUND_OUT_W = 17;
  localparam int TOTAL_OUT_W = 20;

  localparam int UCODE_LEN = 8;
  localparam int PC_W      = 3;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_LOWER,
    OP_MASS,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_UPDATE,
    OP_EMIT_INIT,
    OP_EMIT
  } nmed_op_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_LOOP,
    J_MASS_ZERO,
    J_CONT
  } nmed_jmp_e;

  typedef struct packed {
    nmed_op_e         op;
    nmed_jmp_e        jmp;
    logic [PC_W-1:0]  target;
    logic             fin;
  } nmed_uword_t;

  localparam logic [PC_W-1:0] PC_INIT      = PC_W'(0);
  localparam logic [PC_W-1:0] PC_LOWER     = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MASS      = PC_W'(2);
  localparam logic [PC_W-1:0] PC_SCAN_INIT = PC_W'(3);
  localparam logic [PC_W-1:0] PC_SCAN      = PC_W'(4);
  localparam logic [PC_W-1:0] PC_UPDATE    = PC_W'(5);
  localparam logic [PC_W-1:0] PC_EMIT_INIT = PC_W'(6);
  localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(7);

  localparam nmed_uword_t UCODE [UCODE_LEN] = '{
    '{OP_INIT,      J_NEXT,      PC_INIT,      1'b0},
    '{OP_LOWER,     J_LOOP,      PC_LOWER,     1'b0},
    '{OP_MASS,      J_MASS_ZERO, PC_EMIT_INIT, 1'b0},
    '{OP_SCAN_INIT, J_NEXT,      PC_INIT,      1'b0},
    '{OP_SCAN,      J_LOOP,      PC_SCAN,      1'b0},
    '{OP_UPDATE,    J_CONT,      PC_SCAN_INIT, 1'b0},
    '{OP_EMIT_INIT, J_NEXT,      PC_INIT,      1'b0},
    '{OP_EMIT,      J_LOOP,      PC_EMIT,      1'b1}
  };

endpackage

`default_nettype wire

// ===== hdl/npi_min_entropy_distribution_unit.sv =====
// Loading: class words load at one per cycle while busy is low. After the final class word
// the unit computes the bounds and runs r greedy rounds (r <= n) for n classes, and the n
// result words then follow on consecutive cycles, one per class.
// Throughput: the argmax scan visits one class per cycle, and a new table is accepted only
// once busy is low again; the receiver cannot stall. An asynchronous active-low reset
// clears all state but the count and bound memories.
// ----------------------------------------------------------------------------
// Minimum-entropy distribution unit
// Loads class counts, computes NPI bounds and assigns the leftover mass greedily
// under the control of a small microprogram, then emits one numerator per class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npi_min_entropy_distribution_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [nmed_pkg::COUNT_BITS-1:0]      class_count_i,
  input  wire logic                                 last_class_i,
  output logic                                      strobe_o,
  output logic [nmed_pkg::INDEX_OUT_W-1:0]          class_index_o,
  output logic [nmed_pkg::BOUND_OUT_W-1:0]          bound_count_o,
  output logic [nmed_pkg::TOTAL_OUT_W-1:0]          total_count_o,
  output logic                                      last_result_o,
  output logic                                      mass_error_o
);

  localparam int IDX_W   = nmed_pkg::IDX_W;
  localparam int CNT_W   = nmed_pkg::CNT_W;
  localparam int BOUND_W = nmed_pkg::BOUND_W;
  localparam int TOTAL_W = nmed_pkg::TOTAL_W;
  localparam int WIDE_W  = nmed_pkg::WIDE_W;
  localparam int PC_W    = nmed_pkg::PC_W;
  localparam int NCLS    = nmed_pkg::MAX_CLASSES;

  logic [nmed_pkg::COUNT_BITS-1:0] count_mem [NCLS];
  logic [BOUND_W-1:0]              bound_mem [NCLS];

  logic                 run_q;
  logic [PC_W-1:0]      pc_q, pc_d;
  logic [CNT_W-1:0]     n_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [TOTAL_W-1:0]   lsum_q;
  logic [TOTAL_W-1:0]   mass_q;
  logic [NCLS-1:0]      open_q;
  logic                 err_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     pick_q;
  logic [BOUND_W-1:0]   best_q;
  logic [BOUND_W-1:0]   best_hi_q;
  logic                 have_q;
  logic [CNT_W-1:0]     rounds_q;

  logic                 strobe_q;
  logic [nmed_pkg::INDEX_OUT_W-1:0] index_q;
  logic [nmed_pkg::BOUND_OUT_W-1:0] bound_out_q;
  logic [nmed_pkg::TOTAL_OUT_W-1:0] total_out_q;
  logic                 last_q;
  logic                 err_out_q;

  nmed_pkg::nmed_uword_t cw;
  logic                 accept;
  logic                 load_end;
  logic [nmed_pkg::COUNT_BITS-1:0] cnt_rd;
  logic [BOUND_W-1:0]   bnd_rd;
  logic [BOUND_W-1:0]   lo;
  logic [BOUND_W-1:0]   c_plus;
  logic [BOUND_W-1:0]   hi;
  logic [TOTAL_W-1:0]   mass_new;
  logic [BOUND_W-1:0]   span;
  logic                 span_lt;
  logic [TOTAL_W-1:0]   mass_after;
  logic                 last_idx;
  logic                 rounds_end;
  logic                 cont;
  logic                 take;
  logic                 finish;
  logic                 bnd_we;
  logic [IDX_W-1:0]     bnd_waddr;
  logic [BOUND_W-1:0]   bnd_wdata;

  assign cw       = nmed_pkg::UCODE[pc_q];
  assign accept   = start_i && !run_q;
  assign load_end = last_class_i || (n_q == CNT_W'(NCLS - 1));

  assign cnt_rd = count_mem[idx_q];
  assign bnd_rd = bound_mem[idx_q];
  assign lo     = (cnt_rd == '0) ? '0 : BOUND_W'(cnt_rd) - BOUND_W'(1);
  assign c_plus = BOUND_W'(cnt_rd) + BOUND_W'(1);
  assign hi     = (WIDE_W'(c_plus) > WIDE_W'(total_q)) ? BOUND_W'(total_q) : c_plus;

  assign mass_new   = (total_q > lsum_q) ? total_q - lsum_q : '0;
  assign span       = (best_hi_q > best_q) ? best_hi_q - best_q : '0;
  assign span_lt    = WIDE_W'(span) < WIDE_W'(mass_q);
  assign mass_after = TOTAL_W'(WIDE_W'(mass_q) - WIDE_W'(span));
  assign last_idx   = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
  assign rounds_end = (rounds_q + CNT_W'(1)) == n_q;
  assign cont       = have_q && span_lt && !rounds_end;

  always_comb begin
    unique case (cw.jmp)
      nmed_pkg::J_NEXT:      take = 1'b0;
      nmed_pkg::J_LOOP:      take = !last_idx;
      nmed_pkg::J_MASS_ZERO: take = (mass_new == '0);
      nmed_pkg::J_CONT:      take = cont;
      default:               take = 1'b0;
    endcase
  end

  assign pc_d   = take ? cw.target : pc_q + PC_W'(1);
  assign finish = run_q && cw.fin && !take;

  always_comb begin
    bnd_we    = 1'b0;
    bnd_waddr = idx_q;
    bnd_wdata = lo;
    if (run_q && (cw.op == nmed_pkg::OP_LOWER)) begin
      bnd_we = 1'b1;
    end else if (run_q && (cw.op == nmed_pkg::OP_UPDATE) && have_q) begin
      bnd_we    = 1'b1;
      bnd_waddr = pick_q;
      bnd_wdata = span_lt ? best_hi_q : BOUND_W'(WIDE_W'(best_q) + WIDE_W'(mass_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_mem[n_q[IDX_W-1:0]] <= class_count_i;
    end
    if (bnd_we) begin
      bound_mem[bnd_waddr] <= bnd_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      pc_q        <= nmed_pkg::PC_INIT;
      n_q         <= '0;
      total_q     <= '0;
      lsum_q      <= '0;
      mass_q      <= '0;
      open_q      <= '1;
      err_q       <= 1'b0;
      idx_q       <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      best_hi_q   <= '0;
      have_q      <= 1'b0;
      rounds_q    <= '0;
      strobe_q    <= 1'b0;
      index_q     <= '0;
      bound_out_q <= '0;
      total_out_q <= '0;
      last_q      <= 1'b0;
      err_out_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (!run_q) begin
        if (accept) begin
          n_q     <= n_q + CNT_W'(1);
          total_q <= total_q + TOTAL_W'(class_count_i);
          if (load_end) begin
            run_q <= 1'b1;
            pc_q  <= nmed_pkg::PC_INIT;
          end
        end
      end else begin
        pc_q <= pc_d;
        case (cw.op)
          nmed_pkg::OP_INIT: begin
            idx_q  <= '0;
            lsum_q <= '0;
          end
          nmed_pkg::OP_LOWER: begin
            lsum_q <= lsum_q + TOTAL_W'(lo);
            idx_q  <= idx_q + IDX_W'(1);
          end
          nmed_pkg::OP_MASS: begin
            mass_q   <= mass_new;
            rounds_q <= '0;
          end
          nmed_pkg::OP_SCAN_INIT: begin
            idx_q  <= '0;
            have_q <= 1'b0;
          end
          nmed_pkg::OP_SCAN: begin
            if (open_q[idx_q] && (!have_q || (bnd_rd > best_q))) begin
              best_q    <= bnd_rd;
              best_hi_q <= hi;
              pick_q    <= idx_q;
              have_q    <= 1'b1;
            end
            idx_q <= idx_q + IDX_W'(1);
          end
          nmed_pkg::OP_UPDATE: begin
            if (!have_q) begin
              err_q <= 1'b1;
            end else if (span_lt) begin
              open_q[pick_q] <= 1'b0;
              mass_q         <= mass_after;
              rounds_q       <= rounds_q + CNT_W'(1);
              if (rounds_end && (mass_after != '0)) begin
                err_q <= 1'b1;
              end
            end else begin
              mass_q <= '0;
            end
          end
          nmed_pkg::OP_EMIT_INIT: begin
            idx_q <= '0;
          end
          nmed_pkg::OP_EMIT: begin
            strobe_q    <= 1'b1;
            index_q     <= nmed_pkg::INDEX_OUT_W'(idx_q);
            bound_out_q <= nmed_pkg::BOUND_OUT_W'(bnd_rd);
            total_out_q <= nmed_pkg::TOTAL_OUT_W'(total_q);
            last_q      <= last_idx;
            err_out_q   <= err_q;
            idx_q       <= idx_q + IDX_W'(1);
            if (finish) begin
              run_q   <= 1'b0;
              n_q     <= '0;
              total_q <= '0;
              mass_q  <= '0;
              open_q  <= '1;
              err_q   <= 1'b0;
            end
          end
          default: begin
            run_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign busy_o        = run_q;
  assign strobe_o      = strobe_q;
  assign class_index_o = index_q;
  assign bound_count_o = bound_out_q;
  assign total_count_o = total_out_q;
  assign last_result_o = last_q;
  assign mass_error_o  = err_out_q;

endmodule

`default_nettype wire

// ===== hdl/nmed_checker.sv =====
// ----------------------------------------------------------------------------
// Minimum-entropy distribution port checker
// Watches the ports of the unit and checks the ordering of its result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "npi_min_entropy_distribution_unit_defines.svh"

module nmed_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 busy_o,
  input wire logic                                 strobe_o,
  input wire logic [nmed_pkg::INDEX_OUT_W-1:0]     class_index_o,
  input wire logic [nmed_pkg::TOTAL_OUT_W-1:0]     total_count_o,
  input wire logic                                 last_result_o,
  input wire logic                                 mass_error_o
);

  logic [nmed_pkg::INDEX_OUT_W-1:0] index_next;
  logic                             word_mid;

  assign index_next = class_index_o + nmed_pkg::INDEX_OUT_W'(1);
  assign word_mid   = strobe_o && !last_result_o;

  // A table's words follow each other on consecutive cycles in class order.
  `NMED_ASSERT_CLK(a_index_step,
    word_mid |=> strobe_o && (class_index_o == $past(index_next)),
    "result words out of order")
  `NMED_ASSERT_CLK(a_err_stable,
    word_mid |=> mass_error_o == $past(mass_error_o) && total_count_o == $past(total_count_o),
    "table fields changed within a table")
  `NMED_ASSERT_CLK(a_free_after_last,
    strobe_o && last_result_o |-> !busy_o,
    "unit still busy after its final word")
  `NMED_ASSERT_RST(a_reset_quiet,
    !rst_ni |=> !busy_o && !strobe_o,
    "activity during reset")

endmodule

bind npi_min_entropy_distribution_unit nmed_checker u_nmed_checker (.*);

`default_nettype wire
